[rtl/wtlc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wrapped tick limit clip package
// Shared widths, register indexes and width helpers for the limit clip block.
// ----------------------------------------------------------------------------
package wtlc_pkg;

  localparam int TICK_W       = 16;
  localparam int LIM_W        = 12;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 12;
  localparam int KORG_W       = 2;
  localparam int NUM_CELLS    = 5;
  localparam int TICK_WRAP_DEF = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMITS_ON  = 2'd2;

  localparam logic [LIM_W-1:0] LIMIT_LOW_RST  = 12'd0;
  localparam logic [LIM_W-1:0] LIMIT_HIGH_RST = 12'd4095;

  // Signed width that holds tick + k*wrap for k in -2..2 and the raised
  // upper limit.
  function automatic int cand_w(input int wrap);
    int w2;
    w2 = $clog2(wrap) + 2;
    return ((w2 > TICK_W) ? w2 : TICK_W) + 1;
  endfunction

endpackage

[rtl/wtlc_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wrapped tick limit clip cell
// Scores one wrap alias against the window and keeps the better of it and the
// best alias handed in from the upstream cell.
// ----------------------------------------------------------------------------
module wtlc_cell #(
  parameter int TICK_WRAP = wtlc_pkg::TICK_WRAP_DEF,
  parameter int K         = 0,
  parameter bit FIRST     = 1'b0
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic        [wtlc_pkg::LIM_W-1:0]              lo,
  input  logic signed [wtlc_pkg::cand_w(TICK_WRAP)-1:0]  hi,
  input  logic                                           up_valid,
  output logic                                           up_ready,
  input  logic signed [wtlc_pkg::TICK_W-1:0]             up_tick,
  input  logic signed [wtlc_pkg::cand_w(TICK_WRAP)-1:0]  up_best,
  input  logic signed [wtlc_pkg::cand_w(TICK_WRAP):0]    up_dout,
  input  logic        [wtlc_pkg::KORG_W-1:0]             up_korg,
  output logic                                           dn_valid,
  input  logic                                           dn_ready,
  output logic signed [wtlc_pkg::TICK_W-1:0]             dn_tick,
  output logic signed [wtlc_pkg::cand_w(TICK_WRAP)-1:0]  dn_best,
  output logic signed [wtlc_pkg::cand_w(TICK_WRAP):0]    dn_dout,
  output logic        [wtlc_pkg::KORG_W-1:0]             dn_korg
);

  localparam int CAND_W = wtlc_pkg::cand_w(TICK_WRAP);
  localparam int D_W    = CAND_W + 1;
  localparam logic signed [CAND_W-1:0] OFFSET = CAND_W'(K * TICK_WRAP);
  localparam logic [wtlc_pkg::KORG_W-1:0] KORG = wtlc_pkg::KORG_W'((K < 0) ? -K : K);

  logic                                valid_r;
  logic signed [wtlc_pkg::TICK_W-1:0]  tick_r;
  logic signed [CAND_W-1:0]            best_r;
  logic signed [D_W-1:0]               dout_r;
  logic        [wtlc_pkg::KORG_W-1:0]  korg_r;

  logic signed [CAND_W-1:0] cand;
  logic signed [D_W-1:0]    cand_x;
  logic signed [D_W-1:0]    lo_x;
  logic signed [D_W-1:0]    hi_x;
  logic signed [D_W-1:0]    dout;
  logic                     take;

  assign cand   = CAND_W'(up_tick) + OFFSET;
  assign cand_x = D_W'(cand);
  assign lo_x   = $signed({{(D_W - wtlc_pkg::LIM_W){1'b0}}, lo});
  assign hi_x   = D_W'(hi);

  always_comb begin
    if (cand_x < lo_x) begin
      dout = lo_x - cand_x;
    end else if (cand_x > hi_x) begin
      dout = cand_x - hi_x;
    end else begin
      dout = '0;
    end
  end

  // Ties go to the smaller |k|; between equal |k| the earlier alias, which has the smaller k, wins.
  assign take = FIRST || (dout < up_dout) || ((dout == up_dout) && (KORG < up_korg));

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      tick_r <= up_tick;
      best_r <= take ? cand : up_best;
      dout_r <= take ? dout : up_dout;
      korg_r <= take ? KORG : up_korg;
    end
  end

  assign dn_valid = valid_r;
  assign dn_tick  = tick_r;
  assign dn_best  = best_r;
  assign dn_dout  = dout_r;
  assign dn_korg  = korg_r;

endmodule

[rtl/wtlc_clamp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wrapped tick limit clip output stage
// Clamps the chosen alias into the window and holds the result for the sink.
// ----------------------------------------------------------------------------
module wtlc_clamp #(
  parameter int TICK_WRAP = wtlc_pkg::TICK_WRAP_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic        [wtlc_pkg::LIM_W-1:0]              lo,
  input  logic signed [wtlc_pkg::cand_w(TICK_WRAP)-1:0]  hi,
  input  logic                                           en,
  input  logic                                           up_valid,
  output logic                                           up_ready,
  input  logic signed [wtlc_pkg::TICK_W-1:0]             up_tick,
  input  logic signed [wtlc_pkg::cand_w(TICK_WRAP)-1:0]  up_best,
  output logic                                           out_valid,
  input  logic                                           out_ready,
  output logic signed [wtlc_pkg::TICK_W-1:0]             out_tick,
  output logic                                           out_inside
);

  localparam int CAND_W = wtlc_pkg::cand_w(TICK_WRAP);

  logic                                valid_r;
  logic signed [wtlc_pkg::TICK_W-1:0]  tick_r;
  logic                                inside_r;

  logic signed [CAND_W-1:0]           lo_x;
  logic signed [CAND_W-1:0]           clamped;
  logic                               below;
  logic                               above;
  logic signed [wtlc_pkg::TICK_W-1:0] tick_nxt;
  logic                               inside_nxt;

  assign lo_x  = $signed({{(CAND_W - wtlc_pkg::LIM_W){1'b0}}, lo});
  assign below = up_best < lo_x;
  assign above = up_best > hi;

  always_comb begin
    if (below) begin
      clamped = lo_x;
    end else if (above) begin
      clamped = hi;
    end else begin
      clamped = up_best;
    end
    tick_nxt   = en ? wtlc_pkg::TICK_W'(clamped) : up_tick;
    inside_nxt = !en || (!below && !above);
  end

  assign up_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      tick_r   <= tick_nxt;
      inside_r <= inside_nxt;
    end
  end

  assign out_valid  = valid_r;
  assign out_tick   = tick_r;
  assign out_inside = inside_r;

endmodule

[rtl/wrapped_tick_limit_clip_core.sv]
`timescale 1ns / 1ps
// Pipeline: six stages (five alias cells, one per wrap offset, then the clamp
// register) are loaded in turn, the first at acceptance; out_valid rises when
// the clamp register is loaded. Sink stalls delay this.
// Throughput: one request per cycle; in_ready drops only when every stage is
// full and the sink holds out_ready low.
// Reset (synchronous, rst_n low): stages empty, limits 0 to 4095, limits off.
// ----------------------------------------------------------------------------
// Wrapped tick limit clip core
// Aligns a wrapping servo tick to a joint limit window and clamps it into it.
// ----------------------------------------------------------------------------
module wrapped_tick_limit_clip_core #(
  parameter int TICK_WRAP = wtlc_pkg::TICK_WRAP_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [wtlc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wtlc_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [wtlc_pkg::TICK_W-1:0]    in_tick_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [wtlc_pkg::TICK_W-1:0]    out_tick_out,
  output logic                                  out_inside_window
);

  localparam int CAND_W = wtlc_pkg::cand_w(TICK_WRAP);
  localparam int D_W    = CAND_W + 1;
  localparam int NC     = wtlc_pkg::NUM_CELLS;

  // Configuration registers. Writes are always taken; an index past the
  // register list is dropped.
  logic [wtlc_pkg::LIM_W-1:0] limit_low_r;
  logic [wtlc_pkg::LIM_W-1:0] limit_high_r;
  logic                       limits_on_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_low_r  <= wtlc_pkg::LIMIT_LOW_RST;
      limit_high_r <= wtlc_pkg::LIMIT_HIGH_RST;
      limits_on_r  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        wtlc_pkg::REG_LIMIT_LOW:  limit_low_r  <= cfg_data[wtlc_pkg::LIM_W-1:0];
        wtlc_pkg::REG_LIMIT_HIGH: limit_high_r <= cfg_data[wtlc_pkg::LIM_W-1:0];
        wtlc_pkg::REG_LIMITS_ON:  limits_on_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // When the low limit sits above the high limit the window crosses the wrap
  // point, so the upper bound is moved up by one full wrap.
  logic signed [CAND_W-1:0] hi_eff;
  logic signed [CAND_W-1:0] hi_zx;

  assign hi_zx  = $signed({{(CAND_W - wtlc_pkg::LIM_W){1'b0}}, limit_high_r});
  assign hi_eff = (limit_low_r > limit_high_r) ? (hi_zx + CAND_W'(TICK_WRAP)) : hi_zx;

  // Chain links: link 0 is the input port, link j is the output of cell j-1.
  logic                                valid_s [NC+1];
  logic                                ready_s [NC+1];
  logic signed [wtlc_pkg::TICK_W-1:0]  tick_s  [NC+1];
  logic signed [CAND_W-1:0]            best_s  [NC+1];
  logic signed [D_W-1:0]               dout_s  [NC+1];
  logic        [wtlc_pkg::KORG_W-1:0]  korg_s  [NC+1];

  assign valid_s[0] = in_valid;
  assign in_ready   = ready_s[0];
  assign tick_s[0]  = in_tick_in;
  // The first cell always takes its own alias; these seeds only fill the link.
  assign best_s[0]  = '0;
  assign dout_s[0]  = '0;
  assign korg_s[0]  = '0;

  // Cell j scores the alias tick + (j-2)*TICK_WRAP, in increasing k so that
  // a strict better-than compare hands a tie between k = -1 and k = 1 to the
  // lower one.
  for (genvar j = 0; j < NC; j++) begin : g_cell
    wtlc_cell #(
      .TICK_WRAP (TICK_WRAP),
      .K         (j - 2),
      .FIRST     (j == 0)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .lo       (limit_low_r),
      .hi       (hi_eff),
      .up_valid (valid_s[j]),
      .up_ready (ready_s[j]),
      .up_tick  (tick_s[j]),
      .up_best  (best_s[j]),
      .up_dout  (dout_s[j]),
      .up_korg  (korg_s[j]),
      .dn_valid (valid_s[j+1]),
      .dn_ready (ready_s[j+1]),
      .dn_tick  (tick_s[j+1]),
      .dn_best  (best_s[j+1]),
      .dn_dout  (dout_s[j+1]),
      .dn_korg  (korg_s[j+1])
    );
  end

  // Final stage: clamp the winning alias, or pass the raw tick when limits
  // are off. The distance of the winner is not needed past the chain.
  wtlc_clamp #(
    .TICK_WRAP (TICK_WRAP)
  ) u_clamp (
    .clk        (clk),
    .rst_n      (rst_n),
    .lo         (limit_low_r),
    .hi         (hi_eff),
    .en         (limits_on_r),
    .up_valid   (valid_s[NC]),
    .up_ready   (ready_s[NC]),
    .up_tick    (tick_s[NC]),
    .up_best    (best_s[NC]),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_tick   (out_tick_out),
    .out_inside (out_inside_window)
  );

endmodule

[rtl/wtlc_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wrapped tick limit clip checker
// Port-level checks on the limit clip core, attached by bind.
// ----------------------------------------------------------------------------
module wtlc_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                cfg_valid,
  input logic                                cfg_ready,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [wtlc_pkg::TICK_W-1:0]  out_tick_out,
  input logic                                out_inside_window
);

  // The pipeline only backs up when the sink refuses a finished result.
  a_stall_only_from_sink: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a blocked result");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // Configuration writes are never refused.
  a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

  // A blocked result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_tick_out) && $stable(out_inside_window)))
    else $error("blocked result changed");

endmodule

bind wrapped_tick_limit_clip_core wtlc_chk u_wtlc_chk (.*);
